### src/dep_pkg.sv
// Shared types and constants of the daily evapotranspiration pixel kernel.
package dep_pkg;

   localparam int FLUX_W   = 24;
   localparam int CSR_W    = 23;
   localparam int QUO_BITS = 24;
   localparam int DEN_W    = 51;

   localparam logic signed [27:0] L4_BASE  = 28'sd35789360;
   localparam logic [26:0]        L4_SLOPE = 27'd1475;
   localparam logic [9:0]         ET_SCALE = 10'd675;

   localparam logic signed [23:0] FLUX_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] FLUX_MIN = 24'sh800000;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_DIV   = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef enum logic {
      CSR_DAILY_SOLAR = 1'b0,
      CSR_LONGWAVE    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [FLUX_W-1:0] latent;
      logic [FLUX_W-1:0] rn_daily;
      logic              neg;
      logic              bad;
      logic              sat;
   } side_type;

   function automatic logic [FLUX_W-1:0] clamp_flux(input logic signed [25:0] v);
      logic [FLUX_W-1:0] r;
      if (v > 26'(FLUX_MAX)) begin
         r = FLUX_MAX;
      end else if (v < 26'(FLUX_MIN)) begin
         r = FLUX_MIN;
      end else begin
         r = v[FLUX_W-1:0];
      end
      return r;
   endfunction

   function automatic logic flux_over(input logic signed [25:0] v);
      return (v > 26'(FLUX_MAX)) || (v < 26'(FLUX_MIN));
   endfunction

endpackage

### src/dep_divider.sv
// Pipelined restoring divider with round-to-nearest and a cap at 2^24.
module dep_divider import dep_pkg::*; #(
   parameter int NUM_W = 72
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [NUM_W-1:0]     in_num,
   input  logic [DEN_W-1:0]     in_den,
   input  side_type             in_side,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [QUO_BITS:0]    out_quo,
   output side_type             out_side
);

   localparam int CW   = (NUM_W > DEN_W + QUO_BITS) ? NUM_W : DEN_W + QUO_BITS + 1;
   localparam int NSTG = QUO_BITS + 2;

   logic [NSTG-1:0]     v_ff;
   logic [NSTG:0]       rdy;
   logic [CW-1:0]       rem_ff [NSTG-1];
   logic [DEN_W-1:0]    den_ff [NSTG-1];
   logic [QUO_BITS-1:0] q_ff   [NSTG-1];
   logic                big_ff [NSTG-1];
   side_type            side_ff [NSTG];
   logic [QUO_BITS:0]   quo_ff;
   logic                big_in;
   logic                half_in;

   assign rdy[NSTG] = out_ready;
   assign in_ready  = rdy[0];

   genvar k;
   generate
      for (k = 0; k < NSTG; k++) begin : g_rdy
         assign rdy[k] = !v_ff[k] || rdy[k+1];
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (rdy[k]) begin
               v_ff[k] <= (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   endgenerate

   // The quotient would reach 2^24 or more: the result is capped.
   assign big_in = CW'(in_num) >= (CW'(in_den) << QUO_BITS);

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         rem_ff[0]  <= CW'(in_num);
         den_ff[0]  <= in_den;
         q_ff[0]    <= '0;
         big_ff[0]  <= big_in;
         side_ff[0] <= in_side;
      end
   end

   generate
      for (k = 1; k < NSTG - 1; k++) begin : g_step
         localparam int BIT = QUO_BITS - k;
         logic [CW-1:0]       sub_w;
         logic                ge_w;
         logic [CW-1:0]       rem_in;
         logic [QUO_BITS-1:0] q_in;
         assign sub_w  = CW'(den_ff[k-1]) << BIT;
         assign ge_w   = rem_ff[k-1] >= sub_w;
         assign rem_in = ge_w ? rem_ff[k-1] - sub_w : rem_ff[k-1];
         assign q_in   = q_ff[k-1] | (QUO_BITS'(ge_w) << BIT);
         always_ff @(posedge clock) begin
            if (rdy[k]) begin
               rem_ff[k]  <= rem_in;
               den_ff[k]  <= den_ff[k-1];
               q_ff[k]    <= q_in;
               big_ff[k]  <= big_ff[k-1];
               side_ff[k] <= side_ff[k-1];
            end
         end
      end
   endgenerate

   assign half_in = {rem_ff[NSTG-2][DEN_W-1:0], 1'b0} >= {1'b0, den_ff[NSTG-2]};

   always_ff @(posedge clock) begin
      if (rdy[NSTG-1]) begin
         quo_ff <= big_ff[NSTG-2] ? (QUO_BITS+1)'(1) << QUO_BITS
                                  : {1'b0, q_ff[NSTG-2]} + (QUO_BITS+1)'(half_in);
         side_ff[NSTG-1] <= side_ff[NSTG-2];
      end
   end

   assign out_valid = v_ff[NSTG-1];
   assign out_quo   = quo_ff;
   assign out_side  = side_ff[NSTG-1];

endmodule

### src/daily_evapotranspiration_pixel.sv
// Top level of the per-pixel daily evapotranspiration energy-balance kernel.
//
// One pixel beat on the req_ channel (Rn, G, H, albedo, temperature) gives one
// result beat on the rsp_ channel (latent heat, daily net radiation, daily ET
// and a status code). Both channels use valid/ready; a beat moves when both
// are high. The csr_ channel writes the two scene registers: index 0 is the
// daily solar radiation, index 1 the longwave term. It is always ready and
// must only be used while no pixel is in flight.
//
// From an accepted request to a valid response a pixel passes three front
// stages (fluxes, magnitudes, products), a 26-stage divider (cap check,
// 24 quotient bits, rounding) and an output register. A new pixel is taken
// every cycle while the response side does not stall; throughput is then one
// pixel per clock, set by the one-bit-per-stage divider pipeline.
// Each stage carries its own valid bit and only waits when the stage after it
// is full and stalled, so a stalled receiver fills the pipeline before req_ready
// falls, and bubbles close up. Synchronous reset empties all stages and clears
// both scene registers to zero.
module daily_evapotranspiration_pixel import dep_pkg::*; #(
   parameter int FLUX_FRAC_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [FLUX_W-1:0] req_net_rad,
   input  logic signed [FLUX_W-1:0] req_ground_heat,
   input  logic signed [FLUX_W-1:0] req_sensible_heat,
   input  logic [15:0]              req_surface_albedo,
   input  logic [15:0]              req_surface_temp,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [FLUX_W-1:0] rsp_latent_heat,
   output logic signed [FLUX_W-1:0] rsp_net_rad_daily,
   output logic signed [FLUX_W-1:0] rsp_evapo_daily,
   output logic [1:0]               rsp_pixel_status,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_index,
   input  logic [CSR_W-1:0]         csr_wdata
);

   // The ET scale 675 * 2^(21 - FLUX_FRAC_BITS) is applied as a multiply by 675 and a left shift.
   localparam int SH    = 21 - FLUX_FRAC_BITS;
   localparam int PW    = 59;
   localparam int NUM_W = PW + SH;

   // Scene registers.
   logic [CSR_W-1:0] rs_ff;
   logic [CSR_W-1:0] lw_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_ff <= '0;
         lw_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_DAILY_SOLAR: rs_ff <= csr_wdata;
            CSR_LONGWAVE:    lw_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stall chain: a stage takes a new beat when it is empty or moving on.
   logic a_rdy, b_rdy, c_rdy, f_rdy;
   logic div_in_ready, div_out_valid;
   logic a_v_ff, b_v_ff, c_v_ff, f_v_ff;

   assign f_rdy     = !f_v_ff || rsp_ready;
   assign c_rdy     = !c_v_ff || div_in_ready;
   assign b_rdy     = !b_v_ff || c_rdy;
   assign a_rdy     = !a_v_ff || b_rdy;
   assign req_ready = a_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
      end else begin
         if (a_rdy) a_v_ff <= req_valid;
         if (b_rdy) b_v_ff <= a_v_ff;
         if (c_rdy) c_v_ff <= b_v_ff;
         if (f_rdy) f_v_ff <= div_out_valid;
      end
   end

   // Stage A: available energy, latent heat, daily net radiation and the
   // vaporisation term L4 = 35789360 - 1475 * T.
   logic signed [24:0] a_ae_in;
   logic signed [25:0] a_le_in;
   logic [16:0]        a_om_w;
   logic [39:0]        a_prod_w;
   logic [22:0]        a_rnd_w;
   logic signed [24:0] a_rn24_in;
   logic [26:0]        a_tprod_w;
   logic signed [27:0] a_l4_w;
   logic               a_bad_in;

   assign a_ae_in   = 25'(req_net_rad) - 25'(req_ground_heat);
   assign a_le_in   = 26'(a_ae_in) - 26'(req_sensible_heat);
   assign a_om_w    = 17'h10000 - 17'(req_surface_albedo);
   assign a_prod_w  = 40'(a_om_w) * 40'(rs_ff);
   assign a_rnd_w   = 23'((a_prod_w + 40'd32768) >> 16);
   assign a_rn24_in = $signed({2'b00, a_rnd_w}) - $signed({2'b00, lw_ff});
   assign a_tprod_w = 27'(req_surface_temp) * L4_SLOPE;
   assign a_l4_w    = L4_BASE - $signed({1'b0, a_tprod_w});
   assign a_bad_in  = a_l4_w[27] || (a_l4_w == 28'sd0) || (a_ae_in == 25'sd0);

   logic signed [24:0] a_ae_ff;
   logic signed [25:0] a_le_ff;
   logic signed [24:0] a_rn24_ff;
   logic [25:0]        a_l4_ff;
   logic               a_bad_ff;

   always_ff @(posedge clock) begin
      if (a_rdy) begin
         a_ae_ff   <= a_ae_in;
         a_le_ff   <= a_le_in;
         a_rn24_ff <= a_rn24_in;
         a_l4_ff   <= a_l4_w[25:0];
         a_bad_ff  <= a_bad_in;
      end
   end

   // Stage B: saturated outputs, sign of ET, magnitudes, LE times 675.
   logic [25:0] b_nle_w;
   logic [24:0] b_nrn_w;
   logic [24:0] b_nae_w;
   logic [24:0] b_mle_w;
   logic [23:0] b_mrn_in;
   logic [24:0] b_mae_in;
   logic [34:0] b_mle675_in;
   side_type    b_side_in;

   assign b_nle_w  = -a_le_ff;
   assign b_nrn_w  = -a_rn24_ff;
   assign b_nae_w  = -a_ae_ff;
   assign b_mle_w  = a_le_ff[25] ? b_nle_w[24:0] : a_le_ff[24:0];
   assign b_mrn_in = a_rn24_ff[24] ? b_nrn_w[23:0] : a_rn24_ff[23:0];
   assign b_mae_in = a_ae_ff[24] ? b_nae_w : a_ae_ff;
   assign b_mle675_in = 35'(b_mle_w) * 35'(ET_SCALE);

   always_comb begin
      b_side_in.latent   = clamp_flux(a_le_ff);
      b_side_in.rn_daily = clamp_flux(26'(a_rn24_ff));
      b_side_in.neg      = (a_le_ff[25] ^ a_rn24_ff[24]) ^ a_ae_ff[24];
      b_side_in.bad      = a_bad_ff;
      b_side_in.sat      = flux_over(a_le_ff) || flux_over(26'(a_rn24_ff));
   end

   logic [34:0] b_mle675_ff;
   logic [23:0] b_mrn_ff;
   logic [24:0] b_mae_ff;
   logic [25:0] b_l4_ff;
   side_type    b_side_ff;

   always_ff @(posedge clock) begin
      if (b_rdy) begin
         b_mle675_ff <= b_mle675_in;
         b_mrn_ff    <= b_mrn_in;
         b_mae_ff    <= b_mae_in;
         b_l4_ff     <= a_l4_ff;
         b_side_ff   <= b_side_in;
      end
   end

   // Stage C: numerator product and denominator |Rn - G| * L4.
   logic [PW-1:0]    c_num_ff;
   logic [DEN_W-1:0] c_den_ff;
   side_type         c_side_ff;

   always_ff @(posedge clock) begin
      if (c_rdy) begin
         c_num_ff  <= PW'(b_mle675_ff) * PW'(b_mrn_ff);
         c_den_ff  <= DEN_W'(b_mae_ff) * DEN_W'(b_l4_ff);
         c_side_ff <= b_side_ff;
      end
   end

   logic [NUM_W-1:0]  div_num_w;
   logic [QUO_BITS:0] div_quo;
   side_type          div_side;

   assign div_num_w = NUM_W'(c_num_ff) << SH;

   dep_divider #(
      .NUM_W (NUM_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_v_ff),
      .in_ready  (div_in_ready),
      .in_num    (div_num_w),
      .in_den    (c_den_ff),
      .in_side   (c_side_ff),
      .out_valid (div_out_valid),
      .out_ready (f_rdy),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   // Output stage: sign, saturation and status.
   logic [QUO_BITS:0]   f_nq_w;
   logic [FLUX_W-1:0]   f_et_in;
   logic                f_sat_in;
   status_type          f_status_in;

   assign f_nq_w = -div_quo;

   always_comb begin
      f_sat_in = 1'b0;
      if (div_side.bad) begin
         f_et_in = '0;
      end else if (div_side.neg) begin
         if (div_quo > (QUO_BITS+1)'(25'd8388608)) begin
            f_et_in  = FLUX_MIN;
            f_sat_in = 1'b1;
         end else begin
            f_et_in = f_nq_w[FLUX_W-1:0];
         end
      end else begin
         if (div_quo > (QUO_BITS+1)'(25'd8388607)) begin
            f_et_in  = FLUX_MAX;
            f_sat_in = 1'b1;
         end else begin
            f_et_in = div_quo[FLUX_W-1:0];
         end
      end
      if (div_side.bad) begin
         f_status_in = STATUS_BAD_DIV;
      end else if (div_side.sat || f_sat_in) begin
         f_status_in = STATUS_SATURATED;
      end else begin
         f_status_in = STATUS_OK;
      end
   end

   logic [FLUX_W-1:0] f_le_ff;
   logic [FLUX_W-1:0] f_rnd_ff;
   logic [FLUX_W-1:0] f_et_ff;
   status_type        f_status_ff;

   always_ff @(posedge clock) begin
      if (f_rdy) begin
         f_le_ff     <= div_side.latent;
         f_rnd_ff    <= div_side.rn_daily;
         f_et_ff     <= f_et_in;
         f_status_ff <= f_status_in;
      end
   end

   assign rsp_valid         = f_v_ff;
   assign rsp_latent_heat   = f_le_ff;
   assign rsp_net_rad_daily = f_rnd_ff;
   assign rsp_evapo_daily   = f_et_ff;
   assign rsp_pixel_status  = f_status_ff;

   // A flagged division never reports a nonzero evapotranspiration.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      f_v_ff && (f_status_ff == STATUS_BAD_DIV) |-> (f_et_ff == '0))
      else $error("bad division with nonzero ET");

   // An accepted request always lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> a_v_ff)
      else $error("accepted pixel lost at stage A");

   // A stalled response is kept until taken.
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      f_v_ff && !rsp_ready |=> f_v_ff && $stable(f_et_ff))
      else $error("stalled response dropped or changed");

   // The front end only stalls when stages A, B and C are all occupied.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> a_v_ff && b_v_ff && c_v_ff)
      else $error("request stalled with an empty front stage");

endmodule
